// ----- sv/srp_mutex_ceiling_manager_defines.svh -----
// Assertion macros shared by the mutex ceiling manager RTL.
`ifndef SRP_MUTEX_CEILING_MANAGER_DEFINES_SVH
`define SRP_MUTEX_CEILING_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS
`define SRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRP_ASSERT(lbl, prop, msg)
`define SRP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- sv/srp_mcm_pkg.sv -----
// Types, codes and helpers for the mutex ceiling manager.
`default_nettype none
package srp_mcm_pkg;

  localparam int TID_W   = 3;
  localparam int MID_W   = 3;
  localparam int LVL_W   = 4;
  localparam int CNT_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int TBL_W   = 32;
  localparam int ERR_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_TABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTEXES_CREATED = 1'b1;

  localparam logic FUNC_PEND = 1'b0;
  localparam logic FUNC_POST = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;
  localparam logic [ERR_W-1:0] ERR_UNCREATED = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_POP  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_WAKE = 7'b0010000,
    S_HAND = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             en;
    logic [MID_W-1:0] idx;
  } ceil_req_t;

  function automatic logic [LVL_W-1:0] ceil_of(input logic [TBL_W-1:0] tbl,
                                                input logic [MID_W-1:0] m);
    ceil_of = tbl[{m, 2'b00} +: LVL_W];
  endfunction

endpackage
`default_nettype wire

// ----- sv/srp_mcm_ram.sv -----
// Simple dual-port RAM with registered read, used for task stacks and wait queues.
`default_nettype none
module srp_mcm_ram #(
  parameter int AW = 6,
  parameter int DW = 3
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/srp_mcm_ceil_max.sv -----
// Shared ceiling compare unit: looks up a mutex ceiling and keeps the larger one.
`default_nettype none
module srp_mcm_ceil_max (
  input  wire srp_mcm_pkg::ceil_req_t               req,
  input  wire logic [srp_mcm_pkg::TBL_W-1:0]        ceil_table,
  input  wire logic [srp_mcm_pkg::LVL_W-1:0]        cur,
  output logic      [srp_mcm_pkg::LVL_W-1:0]        max_ceil
);
  import srp_mcm_pkg::*;

  logic [LVL_W-1:0] cand;

  always_comb begin
    cand     = ceil_of(ceil_table, req.idx);
    max_ceil = (req.en && (cand > cur)) ? cand : cur;
  end

endmodule
`default_nettype wire

// ----- sv/srp_mutex_ceiling_manager.sv -----
// Stack resource policy mutex manager top level.
// Pend or failed request: S_EVAL, then S_DONE; a new request is taken only back in S_IDLE.
// Post: S_EVAL, S_POP, S_SCAN, S_WAKE, plus S_HAND when the released mutex has a waiter queued, then S_DONE;
// the ceiling rescan visits one mutex per cycle through the shared compare unit.
// Synchronous active-low reset clears config, ceiling, lock map and all task and queue counters.
// Stack and queue RAM contents are not reset; only entries below the counters are read.
`default_nettype none
`include "srp_mutex_ceiling_manager_defines.svh"
module srp_mutex_ceiling_manager #(
  parameter int MAX_MUTEXES = 8,
  parameter int MAX_TASKS   = 8,
  parameter int STACK_DEPTH = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [srp_mcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srp_mcm_pkg::TBL_W-1:0]       cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_func,
  input  wire logic [srp_mcm_pkg::TID_W-1:0]       in_task_id,
  input  wire logic [srp_mcm_pkg::LVL_W-1:0]       in_task_level,
  input  wire logic [srp_mcm_pkg::MID_W-1:0]       in_mutex_id,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_granted,
  output logic                                     out_blocked,
  output logic      [srp_mcm_pkg::MID_W-1:0]       out_released_mutex,
  output logic                                     out_woken_valid,
  output logic      [srp_mcm_pkg::TID_W-1:0]       out_woken_task,
  output logic      [srp_mcm_pkg::LVL_W-1:0]       out_system_ceiling,
  output logic      [srp_mcm_pkg::ERR_W-1:0]       out_error
);
  import srp_mcm_pkg::*;

  localparam int TW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int MW     = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1;
  localparam int TDEPTH = 1 << TW;
  localparam int MDEPTH = 1 << MW;
  localparam logic [CNT_W-1:0] NM4 = CNT_W'(MAX_MUTEXES);
  localparam logic [CNT_W-1:0] SD4 = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W:0]   NT5 = (CNT_W + 1)'(MAX_TASKS);
  localparam logic [CNT_W-1:0] HOLD_MAX = '1;

  state_t state_r, state_nxt;

  logic [TBL_W-1:0] ceil_tbl_r, ceil_tbl_nxt;
  logic [CNT_W-1:0] created_r, created_nxt;

  logic             func_r, func_nxt;
  logic             tok_r, tok_nxt;
  logic [TID_W-1:0] tid_r, tid_nxt;
  logic [TW-1:0]    tsel_r, tsel_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [MID_W-1:0] mid_r, mid_nxt;
  logic [MW-1:0]    msel_r, msel_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic [LVL_W-1:0]  sys_ceiling_r, sys_ceiling_nxt;
  logic [MDEPTH-1:0] locked_r, locked_nxt;
  logic [CNT_W-1:0]  fill_r [TDEPTH];
  logic [CNT_W-1:0]  fill_nxt [TDEPTH];
  logic [CNT_W-1:0]  hold_r [TDEPTH];
  logic [CNT_W-1:0]  hold_nxt [TDEPTH];
  logic [SLOT_W-1:0] head_r [MDEPTH];
  logic [SLOT_W-1:0] head_nxt [MDEPTH];
  logic [CNT_W-1:0]  wcnt_r [MDEPTH];
  logic [CNT_W-1:0]  wcnt_nxt [MDEPTH];

  logic             res_granted_r, res_granted_nxt;
  logic             res_blocked_r, res_blocked_nxt;
  logic [MID_W-1:0] res_released_r, res_released_nxt;
  logic             res_wvalid_r, res_wvalid_nxt;
  logic [TID_W-1:0] res_wtask_r, res_wtask_nxt;
  logic [ERR_W-1:0] res_err_r, res_err_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_granted_r, out_granted_nxt;
  logic             out_blocked_r, out_blocked_nxt;
  logic [MID_W-1:0] out_released_r, out_released_nxt;
  logic             out_woken_valid_r, out_woken_valid_nxt;
  logic [TID_W-1:0] out_woken_task_r, out_woken_task_nxt;
  logic [LVL_W-1:0] out_ceiling_r, out_ceiling_nxt;
  logic [ERR_W-1:0] out_error_r, out_error_nxt;

  logic              stk_we;
  logic [TW+SLOT_W-1:0] stk_waddr, stk_raddr;
  logic [MID_W-1:0]  stk_wdata, stk_rdata;
  logic              q_we;
  logic [MW+SLOT_W-1:0] q_waddr, q_raddr;
  logic [TID_W-1:0]  q_rdata;

  ceil_req_t        creq;
  logic [LVL_W-1:0] cmax;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  fill_t, fill_dec, hold_t, wc_m;
  logic [SLOT_W-1:0] hd_m;
  logic [CNT_W-1:0]  tid4, w4;

  always_comb begin
    lim      = (created_r < NM4) ? created_r : NM4;
    fill_t   = fill_r[tsel_r];
    fill_dec = fill_t - CNT_W'(1);
    hold_t   = hold_r[tsel_r];
    wc_m     = wcnt_r[msel_r];
    hd_m     = head_r[msel_r];
    tid4     = CNT_W'(in_task_id);
    w4       = CNT_W'(q_rdata);
  end

  assign stk_waddr = {tsel_r, fill_t[SLOT_W-1:0]};
  assign stk_raddr = {tsel_r, fill_dec[SLOT_W-1:0]};
  assign stk_wdata = state_r == S_HAND ? res_released_r : mid_r;
  assign q_waddr   = {msel_r, hd_m + wc_m[SLOT_W-1:0]};
  assign q_raddr   = {msel_r, hd_m};

  srp_mcm_ram #(.AW(TW + SLOT_W), .DW(MID_W)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  srp_mcm_ram #(.AW(MW + SLOT_W), .DW(TID_W)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (tid_r),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  srp_mcm_ceil_max u_ceil_max (
    .req        (creq),
    .ceil_table (ceil_tbl_r),
    .cur        (sys_ceiling_r),
    .max_ceil   (cmax)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    ceil_tbl_nxt     = ceil_tbl_r;
    created_nxt      = created_r;
    func_nxt         = func_r;
    tok_nxt          = tok_r;
    tid_nxt          = tid_r;
    tsel_nxt         = tsel_r;
    level_nxt        = level_r;
    mid_nxt          = mid_r;
    msel_nxt         = msel_r;
    idx_nxt          = idx_r;
    sys_ceiling_nxt  = sys_ceiling_r;
    locked_nxt       = locked_r;
    fill_nxt         = fill_r;
    hold_nxt         = hold_r;
    head_nxt         = head_r;
    wcnt_nxt         = wcnt_r;
    res_granted_nxt  = res_granted_r;
    res_blocked_nxt  = res_blocked_r;
    res_released_nxt = res_released_r;
    res_wvalid_nxt   = res_wvalid_r;
    res_wtask_nxt    = res_wtask_r;
    res_err_nxt      = res_err_r;
    out_valid_nxt       = out_valid_r & ~out_ready;
    out_granted_nxt     = out_granted_r;
    out_blocked_nxt     = out_blocked_r;
    out_released_nxt    = out_released_r;
    out_woken_valid_nxt = out_woken_valid_r;
    out_woken_task_nxt  = out_woken_task_r;
    out_ceiling_nxt     = out_ceiling_r;
    out_error_nxt       = out_error_r;
    stk_we = 1'b0;
    q_we   = 1'b0;
    creq   = '{en: 1'b0, idx: mid_r};

    if (cfg_we) begin
      if (cfg_index == CFG_CEILING_TABLE) begin
        ceil_tbl_nxt = cfg_wdata;
      end else begin
        created_nxt = cfg_wdata[CNT_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt         = in_func;
          tok_nxt          = (CNT_W + 1)'(in_task_id) < NT5;
          tid_nxt          = in_task_id;
          tsel_nxt         = tid4[TW-1:0];
          level_nxt        = in_task_level;
          mid_nxt          = in_mutex_id;
          msel_nxt         = in_mutex_id[MW-1:0];
          res_granted_nxt  = 1'b0;
          res_blocked_nxt  = 1'b0;
          res_released_nxt = '0;
          res_wvalid_nxt   = 1'b0;
          res_wtask_nxt    = '0;
          res_err_nxt      = ERR_NONE;
          state_nxt        = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (tok_r) begin
          if (func_r == FUNC_PEND) begin
            if ({1'b0, mid_r} >= lim) begin
              res_err_nxt = ERR_UNCREATED;
            end else if (hold_t != '0 ||
                         (level_r > sys_ceiling_r && !locked_r[msel_r])) begin
              if (fill_t >= SD4) begin
                res_err_nxt = ERR_FULL;
              end else begin
                creq               = '{en: 1'b1, idx: mid_r};
                sys_ceiling_nxt    = cmax;
                hold_nxt[tsel_r]   = (hold_t != HOLD_MAX) ? hold_t + CNT_W'(1) : hold_t;
                locked_nxt[msel_r] = 1'b1;
                stk_we             = 1'b1;
                fill_nxt[tsel_r]   = fill_t + CNT_W'(1);
                res_granted_nxt    = 1'b1;
              end
            end else begin
              res_blocked_nxt = 1'b1;
              if (!wc_m[CNT_W-1]) begin
                q_we             = 1'b1;
                wcnt_nxt[msel_r] = wc_m + CNT_W'(1);
              end
            end
          end else if (fill_t == '0) begin
            res_err_nxt = ERR_EMPTY;
          end else begin
            fill_nxt[tsel_r] = fill_dec;
            hold_nxt[tsel_r] = (hold_t != '0) ? hold_t - CNT_W'(1) : hold_t;
            state_nxt        = S_POP;
          end
        end
      end
      S_POP: begin
        res_released_nxt            = stk_rdata;
        msel_nxt                    = stk_rdata[MW-1:0];
        locked_nxt[stk_rdata[MW-1:0]] = 1'b0;
        sys_ceiling_nxt             = '0;
        idx_nxt                     = '0;
        state_nxt                   = S_SCAN;
      end
      S_SCAN: begin
        creq            = '{en: (idx_r < lim) && locked_r[idx_r[MW-1:0]],
                            idx: idx_r[MID_W-1:0]};
        sys_ceiling_nxt = cmax;
        idx_nxt         = idx_r + CNT_W'(1);
        if (idx_r == NM4 - CNT_W'(1)) begin
          state_nxt = S_WAKE;
        end
      end
      S_WAKE: begin
        if (wc_m != '0) begin
          tsel_nxt  = w4[TW-1:0];
          state_nxt = S_HAND;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HAND: begin
        state_nxt = S_DONE;
        if (fill_t < SD4) begin
          head_nxt[msel_r]   = hd_m + SLOT_W'(1);
          wcnt_nxt[msel_r]   = wc_m - CNT_W'(1);
          locked_nxt[msel_r] = 1'b1;
          creq               = '{en: 1'b1, idx: res_released_r};
          sys_ceiling_nxt    = cmax;
          stk_we             = 1'b1;
          fill_nxt[tsel_r]   = fill_t + CNT_W'(1);
          hold_nxt[tsel_r]   = (hold_t != HOLD_MAX) ? hold_t + CNT_W'(1) : hold_t;
          res_wvalid_nxt     = 1'b1;
          res_wtask_nxt      = q_rdata;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_granted_nxt     = res_granted_r;
          out_blocked_nxt     = res_blocked_r;
          out_released_nxt    = res_released_r;
          out_woken_valid_nxt = res_wvalid_r;
          out_woken_task_nxt  = res_wtask_r;
          out_ceiling_nxt     = sys_ceiling_r;
          out_error_nxt       = res_err_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ceil_tbl_r    <= '0;
      created_r     <= '0;
      sys_ceiling_r <= '0;
      locked_r      <= '0;
      fill_r        <= '{default: '0};
      hold_r        <= '{default: '0};
      head_r        <= '{default: '0};
      wcnt_r        <= '{default: '0};
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ceil_tbl_r    <= ceil_tbl_nxt;
      created_r     <= created_nxt;
      sys_ceiling_r <= sys_ceiling_nxt;
      locked_r      <= locked_nxt;
      fill_r        <= fill_nxt;
      hold_r        <= hold_nxt;
      head_r        <= head_nxt;
      wcnt_r        <= wcnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r            <= func_nxt;
    tok_r             <= tok_nxt;
    tid_r             <= tid_nxt;
    tsel_r            <= tsel_nxt;
    level_r           <= level_nxt;
    mid_r             <= mid_nxt;
    msel_r            <= msel_nxt;
    idx_r             <= idx_nxt;
    res_granted_r     <= res_granted_nxt;
    res_blocked_r     <= res_blocked_nxt;
    res_released_r    <= res_released_nxt;
    res_wvalid_r      <= res_wvalid_nxt;
    res_wtask_r       <= res_wtask_nxt;
    res_err_r         <= res_err_nxt;
    out_granted_r     <= out_granted_nxt;
    out_blocked_r     <= out_blocked_nxt;
    out_released_r    <= out_released_nxt;
    out_woken_valid_r <= out_woken_valid_nxt;
    out_woken_task_r  <= out_woken_task_nxt;
    out_ceiling_r     <= out_ceiling_nxt;
    out_error_r       <= out_error_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_blocked        = out_blocked_r;
  assign out_released_mutex = out_released_r;
  assign out_woken_valid    = out_woken_valid_r;
  assign out_woken_task     = out_woken_task_r;
  assign out_system_ceiling = out_ceiling_r;
  assign out_error          = out_error_r;

  `SRP_ASSERT(a_accept_to_eval, (in_valid && in_ready) |=> (state_r == S_EVAL),
              "accepted item skipped evaluation")
  `SRP_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE),
              "result raised outside done state")
  `SRP_ASSERT(a_grant_clean,
              (out_valid_r && out_granted_r) |-> (!out_blocked_r && out_error_r == ERR_NONE),
              "grant with block or error")
  `SRP_ASSERT(a_scan_range, (state_r == S_SCAN) |-> (idx_r < NM4),
              "ceiling scan ran past last mutex")
  `SRP_ASSERT_RST(a_reset_clears_out, (!rst_n) |=> !out_valid_r, "result valid after reset")

endmodule
`default_nettype wire

// ----- sim/srp_mutex_ceiling_manager_tb.sv -----
// Self-checking testbench for the stack resource policy mutex ceiling manager.
`default_nettype none
module srp_mutex_ceiling_manager_tb;
  import srp_mcm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_TASKS   = 8;
  localparam int NUM_MUTEXES = 8;
  localparam int STACK_SLOTS = 8;
  localparam int QUEUE_SLOTS = 8;

  typedef struct packed {
    logic             granted;
    logic             blocked;
    logic [MID_W-1:0] released;
    logic             woken_valid;
    logic [TID_W-1:0] woken_task;
    logic [LVL_W-1:0] ceiling;
    logic [ERR_W-1:0] err;
  } mcm_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TBL_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [TID_W-1:0]     in_task_id;
  logic [LVL_W-1:0]     in_task_level;
  logic [MID_W-1:0]     in_mutex_id;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_granted;
  logic                 out_blocked;
  logic [MID_W-1:0]     out_released_mutex;
  logic                 out_woken_valid;
  logic [TID_W-1:0]     out_woken_task;
  logic [LVL_W-1:0]     out_system_ceiling;
  logic [ERR_W-1:0]     out_error;

  srp_mutex_ceiling_manager dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_task_id         (in_task_id),
    .in_task_level      (in_task_level),
    .in_mutex_id        (in_mutex_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted        (out_granted),
    .out_blocked        (out_blocked),
    .out_released_mutex (out_released_mutex),
    .out_woken_valid    (out_woken_valid),
    .out_woken_task     (out_woken_task),
    .out_system_ceiling (out_system_ceiling),
    .out_error          (out_error)
  );

  // Predicted state of the manager.
  logic [TBL_W-1:0] ceil_table;
  logic [CNT_W-1:0] created_cnt;
  logic [LVL_W-1:0] sys_ceil;
  logic [7:0]       lock_map;
  logic [MID_W-1:0] held_stack [NUM_TASKS][STACK_SLOTS];
  logic [CNT_W-1:0] held_depth [NUM_TASKS];
  logic [CNT_W-1:0] hold_cnt   [NUM_TASKS];
  logic [TID_W-1:0] waiters    [NUM_MUTEXES][QUEUE_SLOTS];
  logic [SLOT_W-1:0] waiter_head [NUM_MUTEXES];
  logic [CNT_W-1:0] waiter_cnt [NUM_MUTEXES];

  mcm_result_t predicted_outcomes [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [LVL_W-1:0] mutex_ceiling(input logic [MID_W-1:0] m);
    logic [TBL_W-1:0] shifted;
    shifted = ceil_table >> (m * 4);
    return shifted[LVL_W-1:0];
  endfunction

  function automatic int created_limit();
    return (created_cnt < NUM_MUTEXES) ? int'(created_cnt) : NUM_MUTEXES;
  endfunction

  function automatic mcm_result_t resolve_request(input logic func, input logic [TID_W-1:0] tid,
                                                  input logic [LVL_W-1:0] lvl,
                                                  input logic [MID_W-1:0] mid);
    mcm_result_t res;
    int          lim;
    int          i;
    logic [MID_W-1:0]  rel;
    logic [TID_W-1:0]  w;
    logic [SLOT_W-1:0] slot;
    res = '0;
    lim = created_limit();
    if (func == FUNC_PEND) begin
      if (int'(mid) >= lim) begin
        res.err = ERR_UNCREATED;
      end else if (hold_cnt[tid] != 0 || (lvl > sys_ceil && !lock_map[mid])) begin
        if (held_depth[tid] >= STACK_SLOTS) begin
          res.err = ERR_FULL;
        end else begin
          if (hold_cnt[tid] != 4'd15) hold_cnt[tid]++;
          if (mutex_ceiling(mid) > sys_ceil) sys_ceil = mutex_ceiling(mid);
          lock_map[mid] = 1'b1;
          held_stack[tid][held_depth[tid][2:0]] = mid;
          held_depth[tid]++;
          res.granted = 1'b1;
        end
      end else begin
        res.blocked = 1'b1;
        if (waiter_cnt[mid] < QUEUE_SLOTS) begin
          slot = waiter_head[mid] + waiter_cnt[mid][2:0];
          waiters[mid][slot] = tid;
          waiter_cnt[mid]++;
        end
      end
    end else if (held_depth[tid] == 0) begin
      res.err = ERR_EMPTY;
    end else begin
      held_depth[tid]--;
      rel = held_stack[tid][held_depth[tid][2:0]];
      if (hold_cnt[tid] != 0) hold_cnt[tid]--;
      res.released = rel;
      lock_map[rel] = 1'b0;
      sys_ceil = '0;
      for (i = 0; i < lim; i++) begin
        if (lock_map[i] && mutex_ceiling(MID_W'(i)) > sys_ceil)
          sys_ceil = mutex_ceiling(MID_W'(i));
      end
      if (waiter_cnt[rel] != 0) begin
        w = waiters[rel][waiter_head[rel]];
        if (held_depth[w] < STACK_SLOTS) begin
          waiter_head[rel]++;
          waiter_cnt[rel]--;
          lock_map[rel] = 1'b1;
          if (mutex_ceiling(rel) > sys_ceil) sys_ceil = mutex_ceiling(rel);
          held_stack[w][held_depth[w][2:0]] = rel;
          held_depth[w]++;
          if (hold_cnt[w] != 4'd15) hold_cnt[w]++;
          res.woken_valid = 1'b1;
          res.woken_task = w;
        end
      end
    end
    res.ceiling = sys_ceil;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 200) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic compare_result(input mcm_result_t e);
    if (out_granted !== e.granted)
      report_mismatch($sformatf("granted %0b, expected %0b", out_granted, e.granted));
    if (out_blocked !== e.blocked)
      report_mismatch($sformatf("blocked %0b, expected %0b", out_blocked, e.blocked));
    if (out_released_mutex !== e.released)
      report_mismatch($sformatf("released_mutex %0d, expected %0d",
                                out_released_mutex, e.released));
    if (out_woken_valid !== e.woken_valid)
      report_mismatch($sformatf("woken_valid %0b, expected %0b",
                                out_woken_valid, e.woken_valid));
    if (out_woken_task !== e.woken_task)
      report_mismatch($sformatf("woken_task %0d, expected %0d", out_woken_task, e.woken_task));
    if (out_system_ceiling !== e.ceiling)
      report_mismatch($sformatf("system_ceiling %0d, expected %0d",
                                out_system_ceiling, e.ceiling));
    if (out_error !== e.err)
      report_mismatch($sformatf("error %0d, expected %0d", out_error, e.err));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_outcomes.size() == 0) report_mismatch("result with no request pending");
      else compare_result(predicted_outcomes.pop_front());
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(input logic func, input logic [TID_W-1:0] tid,
                              input logic [LVL_W-1:0] lvl, input logic [MID_W-1:0] mid);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_task_id    <= tid;
    in_task_level <= lvl;
    in_mutex_id   <= mid;
    do @(posedge clk); while (!in_ready);
    predicted_outcomes.push_back(resolve_request(func, tid, lvl, mid));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TBL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CEILING_TABLE) ceil_table = data;
    else created_cnt = data[CNT_W-1:0];
  endtask

  task automatic test_reset_errors();
    send_request(FUNC_PEND, 3'd0, 4'd15, 3'd7);
    send_request(FUNC_POST, 3'd7, 4'd0, 3'd0);
    send_request(FUNC_PEND, 3'd5, 4'd0, 3'd0);
  endtask

  task automatic test_grant_block_handoff();
    wait_idle();
    write_register(CFG_CEILING_TABLE, 32'hF654_3210);
    write_register(CFG_MUTEXES_CREATED, 32'd8);
    send_request(FUNC_PEND, 3'd0, 4'd0, 3'd0);
    send_request(FUNC_PEND, 3'd1, 4'd15, 3'd7);
    send_request(FUNC_PEND, 3'd2, 4'd15, 3'd0);
    send_request(FUNC_PEND, 3'd1, 4'd0, 3'd0);
    send_request(FUNC_POST, 3'd1, 4'd0, 3'd0);
    send_request(FUNC_POST, 3'd1, 4'd0, 3'd0);
    send_request(FUNC_POST, 3'd0, 4'd0, 3'd0);
    send_request(FUNC_POST, 3'd2, 4'd0, 3'd0);
  endtask

  task automatic test_stack_full_no_handoff();
    send_request(FUNC_PEND, 3'd3, 4'd15, 3'd6);
    send_request(FUNC_PEND, 3'd4, 4'd2, 3'd6);
    send_request(FUNC_PEND, 3'd4, 4'd15, 3'd5);
    repeat (7) send_request(FUNC_PEND, 3'd4, 4'd0, 3'd5);
    send_request(FUNC_PEND, 3'd4, 4'd0, 3'd1);
    send_request(FUNC_POST, 3'd3, 4'd0, 3'd0);
  endtask

  task automatic test_random_traffic(input logic [TBL_W-1:0] table_val,
                                     input logic [TBL_W-1:0] created_val, input int n_items);
    logic [TID_W-1:0] tid;
    logic [LVL_W-1:0] lvl;
    logic [MID_W-1:0] any_mid;
    logic             any_func;
    int               pick;
    int               lim;
    wait_idle();
    write_register(CFG_CEILING_TABLE, table_val);
    write_register(CFG_MUTEXES_CREATED, created_val);
    repeat (n_items) begin
      tid      = TID_W'($urandom_range(NUM_TASKS - 1));
      lvl      = LVL_W'($urandom_range(15));
      any_mid  = MID_W'($urandom_range(NUM_MUTEXES - 1));
      any_func = 1'($urandom_range(1));
      pick     = $urandom_range(99);
      lim      = created_limit();
      if (pick < 8)
        send_request(any_func, tid, lvl, any_mid);
      else if (pick < 50 && held_depth[tid] != 0)
        send_request(FUNC_POST, tid, lvl, any_mid);
      else if (lim == 0)
        send_request(FUNC_PEND, tid, lvl, any_mid);
      else
        send_request(FUNC_PEND, tid, lvl, MID_W'($urandom_range(lim - 1)));
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_CEILING_TABLE;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_PEND;
    in_task_id    <= '0;
    in_task_level <= '0;
    in_mutex_id   <= '0;
    out_ready     <= 1'b0;
    ceil_table  = '0;
    created_cnt = '0;
    sys_ceil    = '0;
    lock_map    = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      held_depth[t] = '0;
      hold_cnt[t]   = '0;
      for (int s = 0; s < STACK_SLOTS; s++) held_stack[t][s] = '0;
    end
    for (int m = 0; m < NUM_MUTEXES; m++) begin
      waiter_head[m] = '0;
      waiter_cnt[m]  = '0;
      for (int s = 0; s < QUEUE_SLOTS; s++) waiters[m][s] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 7;
    recv_stall_pct = 52;
    test_reset_errors();
    test_grant_block_handoff();
    test_stack_full_no_handoff();
    test_random_traffic(32'hFFFF_FFFF, 32'd8, 300);
    test_random_traffic($urandom, $urandom_range(1, 7), 300);

    send_idle_pct  = 52;
    recv_stall_pct = 7;
    test_random_traffic(32'h0, 32'd0, 300);
    test_random_traffic($urandom, 32'd8, 300);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(32'h0, 32'd8, 300);
    test_random_traffic($urandom, 32'd1, 300);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
